@@ sv/i695fd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i695fd_pkg
// Shared types and constants of the object-file number and string decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package i695fd_pkg;

	// Width of the internal number accumulator; results report the low 32 bits.
	localparam int VALUE_WIDTH = 32;
	localparam int OUT_VALUE_W = 32;
	localparam int LEN_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_CODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_CODE  = 1'd1;

	// Reset values of the string length codes.
	localparam logic [7:0] SHORT_CODE_RST = 8'hDE;
	localparam logic [7:0] LONG_CODE_RST  = 8'hDF;

	// Lead byte limits.
	localparam logic [7:0] LEAD_EXT     = 8'h80;
	localparam logic [7:0] NUM_LEAD_MAX = 8'h88;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_NUMBER = 2'd0,
		KIND_BYTE   = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	// One input item.
	typedef struct packed {
		logic       eoi;
		logic       op;
		logic [7:0] in_byte;
	} item_t;

	// One result item.
	typedef struct packed {
		kind_t                         kind;
		logic signed [OUT_VALUE_W-1:0] value;
		logic [7:0]                    sbyte;
		logic                          last;
	} res_t;

endpackage

`default_nettype wire

@@ sv/i695fd_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i695fd_in_stage
// Input register: captures one stream item per cycle for the decode stage while it is empty or the result side is free.
// ----------------------------------------------------------------------------
`default_nettype none

module i695fd_in_stage (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [7:0]        s_tdata,   // [7:0] in_byte
	input  wire  [1:0]        s_tuser,   // [0] operation, [1] end_of_input
	input  wire               out_free,
	output logic              valid_s1,
	output i695fd_pkg::item_t item_s1
);

	// The register empties into the decoder whenever the result side is free.
	assign s_tready = !valid_s1 || out_free;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.in_byte <= s_tdata;
			item_s1.op      <= s_tuser[0];
			item_s1.eoi     <= s_tuser[1];
		end
	end

endmodule

`default_nettype wire

@@ sv/i695fd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i695fd_core
// Field decoder: per-byte state update and result selection, plus the
// string length code registers.
// ----------------------------------------------------------------------------
`default_nettype none

module i695fd_core (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [i695fd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [i695fd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                   fire,
	input  i695fd_pkg::item_t                     item_s1,
	output logic                                  res_valid,
	output i695fd_pkg::res_t                      res
);

	localparam int VW = i695fd_pkg::VALUE_WIDTH;
	localparam int LW = i695fd_pkg::LEN_W;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_NUM_FIRST = 3'd1,
		PH_NUM_REST  = 3'd2,
		PH_STR_SHORT = 3'd3,
		PH_STR_HI    = 3'd4,
		PH_STR_LO    = 3'd5,
		PH_STR_BODY  = 3'd6
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [LW-1:0]   left_q, left_d;
	logic [VW-1:0]   acc_q, acc_d;
	logic [7:0]      short_code_q;
	logic [7:0]      long_code_q;
	logic [LW-1:0]   left_dec;
	logic [LW-1:0]   str_len;
	logic            do_body;
	logic [7:0]      b;

	assign b        = item_s1.in_byte;
	assign left_dec = left_q - {{(LW-1){1'b0}}, (left_q != '0)};

	// Configuration registers; bits above the code width are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_code_q <= i695fd_pkg::SHORT_CODE_RST;
			long_code_q  <= i695fd_pkg::LONG_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i695fd_pkg::CFG_SHORT_CODE: short_code_q <= cfg_data[7:0];
				i695fd_pkg::CFG_LONG_CODE:  long_code_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Next state and result for the item in the input register.
	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		acc_d     = acc_q;
		res_valid = 1'b0;
		res.kind  = i695fd_pkg::KIND_ERROR;
		res.value = '0;
		res.sbyte = 8'h00;
		res.last  = 1'b1;
		do_body   = 1'b0;
		str_len   = '0;

		if (item_s1.eoi) begin
			res_valid = 1'b1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (!item_s1.op) begin
						if (b < i695fd_pkg::LEAD_EXT) begin
							res_valid = 1'b1;
							res.kind  = i695fd_pkg::KIND_NUMBER;
							res.value = {{(i695fd_pkg::OUT_VALUE_W-8){1'b0}}, b};
						end else if (b > i695fd_pkg::NUM_LEAD_MAX) begin
							res_valid = 1'b1;
						end else if (b == i695fd_pkg::LEAD_EXT) begin
							res_valid = 1'b1;
							res.kind  = i695fd_pkg::KIND_NUMBER;
						end else begin
							left_d  = {{(LW-7){1'b0}}, b[6:0]};
							acc_d   = '0;
							phase_d = PH_NUM_FIRST;
						end
					end else begin
						if (b < i695fd_pkg::LEAD_EXT) begin
							do_body = 1'b1;
							str_len = {{(LW-8){1'b0}}, b};
						end else if (b == short_code_q) begin
							phase_d = PH_STR_SHORT;
						end else if (b == long_code_q) begin
							phase_d = PH_STR_HI;
						end else begin
							res_valid = 1'b1;
						end
					end
				end
				PH_NUM_FIRST, PH_NUM_REST: begin
					if (phase_q == PH_NUM_FIRST) begin
						acc_d = {{(VW-8){b[7]}}, b};
					end else begin
						acc_d = {acc_q[VW-9:0], b};
					end
					phase_d = PH_NUM_REST;
					left_d  = left_dec;
					if (left_dec == '0) begin
						res_valid = 1'b1;
						res.kind  = i695fd_pkg::KIND_NUMBER;
						res.value = acc_d[i695fd_pkg::OUT_VALUE_W-1:0];
					end
				end
				PH_STR_SHORT: begin
					do_body = 1'b1;
					str_len = {{(LW-8){1'b0}}, b};
				end
				PH_STR_HI: begin
					acc_d   = {{(VW-16){1'b0}}, b, 8'h00};
					phase_d = PH_STR_LO;
				end
				PH_STR_LO: begin
					do_body = 1'b1;
					str_len = {acc_q[15:8], b};
				end
				PH_STR_BODY: begin
					left_d    = left_dec;
					res_valid = 1'b1;
					res.kind  = i695fd_pkg::KIND_BYTE;
					res.sbyte = b;
					res.last  = (left_dec == '0);
				end
				default: begin
					res_valid = 1'b1;
				end
			endcase
		end

		// Start of a string body, or the mark of an empty string.
		if (do_body) begin
			if (str_len == '0) begin
				res_valid = 1'b1;
				res.kind  = i695fd_pkg::KIND_EMPTY;
			end else begin
				left_d  = str_len;
				phase_d = PH_STR_BODY;
			end
		end

		// A final result or an error closes the field.
		if (res_valid && (res.last || res.kind == i695fd_pkg::KIND_ERROR)) begin
			phase_d = PH_IDLE;
			left_d  = '0;
		end
	end

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= '0;
			acc_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/i695fd_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i695fd_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i695fd_out_stage (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              load,
	input  i695fd_pkg::res_t res,
	output logic             out_free,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [39:0]      m_tdata,   // [31:0] number_value, [39:32] string_byte
	output logic [1:0]       m_tuser,   // [1:0] result_kind
	output logic             m_tlast    // last
);

	i695fd_pkg::res_t res_q;

	// A new result may enter when the register is empty or being drained.
	assign out_free = !m_tvalid || m_tready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tdata = {res_q.sbyte, res_q.value};
	assign m_tuser = res_q.kind;
	assign m_tlast = res_q.last;

endmodule

`default_nettype wire

@@ sv/ieee695_field_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieee695_field_decoder
// Byte-stream decoder for the number and string fields of an object file.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one stream byte per item in s_tdata, with the
//   field kind (0 number, 1 string) in s_tuser[0] and an end-of-stream flag
//   in s_tuser[1]. The field kind is only looked at on a field's lead byte.
//   The master channel gives zero or one result per item: kind in m_tuser,
//   the number in m_tdata[31:0], a string byte in m_tdata[39:32], and
//   m_tlast on the final result of a field and on every error.
//   The write port sets the short and long string length codes; write it
//   only while no item is in flight.
//   An accepted item waits in the input register; its result waits in the
//   result register. One item is accepted every cycle while the result
//   side is free; the decode state is one register loop updated per byte.
//   When the receiver stalls, the result register holds and s_tready drops
//   once the input register is also full; nothing is lost or repeated.
//   Reset clears both stages, returns the decoder to awaiting a lead byte
//   and restores the codes to 0xDE and 0xDF.
// ----------------------------------------------------------------------------
`default_nettype none

module ieee695_field_decoder (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [7:0]                         s_tdata,   // [7:0] in_byte
	input  wire  [1:0]                         s_tuser,   // [0] operation, [1] end_of_input
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [39:0]                        m_tdata,   // [31:0] number_value,
	                                                      // [39:32] string_byte
	output logic [1:0]                         m_tuser,   // [1:0] result_kind
	output logic                               m_tlast,   // last
	input  wire                                cfg_we,
	input  wire  [i695fd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [i695fd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic              out_free;
	logic              valid_s1;
	logic              fire;
	logic              res_valid;
	i695fd_pkg::item_t item_s1;
	i695fd_pkg::res_t  res;

	assign fire = valid_s1 && out_free;

	// Input register.
	i695fd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.out_free (out_free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Decode logic and state.
	i695fd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register.
	i695fd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire && res_valid),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ sv/i695fd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i695fd_checker
// Port-level checks of the field decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i695fd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire [1:0]  m_tuser,
	input wire        m_tlast
);

	// A stalled result item holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result item changed while stalled");

	// Errors, numbers and empty strings always close a field.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == i695fd_pkg::KIND_ERROR || m_tuser == i695fd_pkg::KIND_NUMBER
			|| m_tuser == i695fd_pkg::KIND_EMPTY) |-> m_tlast)
		else $error("field-closing result without last");

	// The number value is zero on every result that is not a number.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != i695fd_pkg::KIND_NUMBER |-> m_tdata[31:0] == 32'd0)
		else $error("number value set on a non-number result");

	// The string byte is zero on every result that is not a string byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != i695fd_pkg::KIND_BYTE |-> m_tdata[39:32] == 8'd0)
		else $error("string byte set on a non-byte result");

endmodule

bind ieee695_field_decoder i695fd_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

@@ test/ieee695_field_decoder_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieee695_field_decoder_chk
// Watches both stream channels and the write port of the field decoder,
// decodes every accepted byte in its own copy of the decoder state and
// compares each accepted result, field by field, against the oldest one
// it expects.
// ----------------------------------------------------------------------------

module ieee695_field_decoder_chk (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	input  wire                                s_tready,
	input  wire  [7:0]                         s_tdata,   // [7:0] in_byte
	input  wire  [1:0]                         s_tuser,   // [0] operation, [1] end_of_input
	input  wire                                m_tvalid,
	input  wire                                m_tready,
	input  wire  [39:0]                        m_tdata,   // [31:0] number_value,
	                                                      // [39:32] string_byte
	input  wire  [1:0]                         m_tuser,   // [1:0] result_kind
	input  wire                                m_tlast,
	input  wire                                cfg_we,
	input  wire  [i695fd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [i695fd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                 fail_count,
	output int                                 pending_results
);

	import i695fd_pkg::*;

	// Where the decoder stands within a field.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUM_FIRST,
		ST_NUM_REST,
		ST_STR_SHORT,
		ST_STR_HI,
		ST_STR_LO,
		ST_STR_BODY
	} field_state_t;

	field_state_t           dec_state;
	logic [LEN_W-1:0]       remaining;
	logic [VALUE_WIDTH-1:0] acc;
	logic [7:0]             short_code;
	logic [7:0]             long_code;
	res_t                   decoded_q[$];
	item_t                  in_item;
	res_t                   seen;

	// Prints one line per mismatch and counts it.
	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		fail_count++;
	endtask

	// Queues one decoded result; a final result or an error ends the field.
	task automatic push_result(input kind_t kind, input logic [OUT_VALUE_W-1:0] value,
	                           input logic [7:0] sbyte, input logic last);
		res_t r;
		r.kind  = kind;
		r.value = value;
		r.sbyte = sbyte;
		r.last  = last;
		decoded_q.push_back(r);
		if (last || kind == KIND_ERROR) begin
			dec_state = ST_IDLE;
			remaining = '0;
		end
	endtask

	// A known string length either ends the field at once or opens the body.
	task automatic open_body(input logic [LEN_W-1:0] len);
		if (len == 0) begin
			push_result(KIND_EMPTY, '0, '0, 1'b1);
		end else begin
			remaining = len;
			dec_state = ST_STR_BODY;
		end
	endtask

	// Advances the decoder by one accepted stream item.
	task automatic decode_item(input item_t it);
		if (it.eoi) begin
			push_result(KIND_ERROR, '0, '0, 1'b1);
		end else begin
			case (dec_state)
				ST_IDLE: begin
					if (!it.op) begin
						if (it.in_byte < LEAD_EXT)
							push_result(KIND_NUMBER, OUT_VALUE_W'(it.in_byte), '0, 1'b1);
						else if (it.in_byte > NUM_LEAD_MAX)
							push_result(KIND_ERROR, '0, '0, 1'b1);
						else if (it.in_byte == LEAD_EXT)
							push_result(KIND_NUMBER, '0, '0, 1'b1);
						else begin
							remaining = LEN_W'(it.in_byte[6:0]);
							acc       = '0;
							dec_state = ST_NUM_FIRST;
						end
					end else if (it.in_byte < LEAD_EXT) begin
						open_body(LEN_W'(it.in_byte));
					end else if (it.in_byte == short_code) begin
						// The short code wins when both codes are equal.
						dec_state = ST_STR_SHORT;
					end else if (it.in_byte == long_code) begin
						dec_state = ST_STR_HI;
					end else begin
						push_result(KIND_ERROR, '0, '0, 1'b1);
					end
				end
				ST_NUM_FIRST, ST_NUM_REST: begin
					// The first number byte is sign-extended, later ones shift in.
					if (dec_state == ST_NUM_FIRST)
						acc = {{(VALUE_WIDTH-8){it.in_byte[7]}}, it.in_byte};
					else
						acc = {acc[VALUE_WIDTH-9:0], it.in_byte};
					dec_state = ST_NUM_REST;
					if (remaining != 0)
						remaining = remaining - 1'b1;
					if (remaining == 0)
						push_result(KIND_NUMBER, acc[OUT_VALUE_W-1:0], '0, 1'b1);
				end
				ST_STR_SHORT: begin
					open_body(LEN_W'(it.in_byte));
				end
				ST_STR_HI: begin
					acc       = '0;
					acc[15:8] = it.in_byte;
					dec_state = ST_STR_LO;
				end
				ST_STR_LO: begin
					open_body({acc[15:8], it.in_byte});
				end
				ST_STR_BODY: begin
					if (remaining != 0)
						remaining = remaining - 1'b1;
					push_result(KIND_BYTE, '0, it.in_byte, remaining == 0);
				end
				default: begin
					push_result(KIND_ERROR, '0, '0, 1'b1);
				end
			endcase
		end
	endtask

	// Compares one accepted result with the oldest decoded one.
	task automatic check_result(input res_t got);
		res_t want;
		if (decoded_q.size() == 0) begin
			flag_mismatch($sformatf("unexpected result: kind %0d value %0d byte %02h last %0b",
			                        got.kind, got.value, got.sbyte, got.last));
		end else begin
			want = decoded_q.pop_front();
			if (got.kind !== want.kind || got.value !== want.value ||
			    got.sbyte !== want.sbyte || got.last !== want.last)
				flag_mismatch($sformatf(
					{"got kind %0d value %0d byte %02h last %0b, ",
					 "want kind %0d value %0d byte %02h last %0b"},
					got.kind, got.value, got.sbyte, got.last,
					want.kind, want.value, want.sbyte, want.last));
		end
	endtask

	// Results are checked before new items are decoded; register writes
	// only ever happen while no item is in flight.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_state  = ST_IDLE;
			remaining  = '0;
			acc        = '0;
			short_code = SHORT_CODE_RST;
			long_code  = LONG_CODE_RST;
			decoded_q.delete();
			fail_count      = 0;
			pending_results = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = {m_tuser, m_tdata[31:0], m_tdata[39:32], m_tlast};
				check_result(seen);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SHORT_CODE: short_code = cfg_data;
					CFG_LONG_CODE:  long_code  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				in_item = {s_tuser[1], s_tuser[0], s_tdata};
				decode_item(in_item);
			end
			pending_results = decoded_q.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the object-file field decoder with a directed set of numbers,
// strings and broken fields, then with random field sequences under four
// flow-control regimes and four settings of the string length codes. A
// separate checker decodes alongside and counts mismatches.
// ----------------------------------------------------------------------------

module tb;

	import i695fd_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_ITEMS   = 350;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending_results;
	int src_idle_pct;
	int sink_stall_pct;
	int items_sent;
	int cycle_count;

	// Code values currently loaded, so that random fields can be well formed.
	logic [7:0] cur_short;
	logic [7:0] cur_long;

	// Per phase: code settings and flow-control pressure.
	logic [7:0] short_set [4] = '{8'h80, 8'hFF, 8'h90, SHORT_CODE_RST};
	logic [7:0] long_set  [4] = '{8'hFF, 8'h80, 8'h90, LONG_CODE_RST};
	int         src_pct   [4] = '{0, 73, 0, 38};
	int         sink_pct  [4] = '{0, 0, 73, 38};

	ieee695_field_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ieee695_field_decoder_chk i_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always #(CLK_HALF) clk = ~clk;

	// Receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offers one item after a random idle gap and returns once it is taken.
	// Valid stays high so that back-to-back items need no second assignment.
	task automatic send_item(input logic op, input logic [7:0] data, input logic eoi);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= {eoi, op};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Holds the sender until every decoded result has come out, then lets
	// any result-free item still in the pipeline drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Loads the short string length code and then the long one.
	task automatic set_codes(input logic [7:0] short_val, input logic [7:0] long_val);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SHORT_CODE;
		cfg_data  <= short_val;
		@(posedge clk);
		cfg_index <= CFG_LONG_CODE;
		cfg_data  <= long_val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_short = short_val;
		cur_long  = long_val;
	endtask

	// Sends one random field: mostly well-formed numbers and strings with
	// random content, plus stray bytes and fields cut short by end of input.
	task automatic send_field();
		int pick;
		int form;
		int n;
		int len;
		int k;
		logic [7:0] hi;
		logic [7:0] lo;
		pick = $urandom_range(99);
		if (pick < 40) begin
			n = $urandom_range(8);
			if (n == 0) begin
				if ($urandom_range(9) == 0)
					send_item(1'b0, LEAD_EXT, 1'b0);
				else
					send_item(1'b0, 8'($urandom_range(127)), 1'b0);
			end else begin
				send_item(1'b0, LEAD_EXT + 8'(n), 1'b0);
				for (k = 0; k < n; k++)
					send_item(1'($urandom), 8'($urandom), 1'b0);
			end
		end else if (pick < 80) begin
			form = $urandom_range(2);
			// With equal codes the long form cannot be reached.
			if (form == 2 && cur_long == cur_short)
				form = 1;
			case (form)
				0: begin
					len = ($urandom_range(15) == 0) ? $urandom_range(127) : $urandom_range(7);
					send_item(1'b1, 8'(len), 1'b0);
				end
				1: begin
					len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(8);
					send_item(1'b1, cur_short, 1'b0);
					send_item(1'($urandom), 8'(len), 1'b0);
				end
				default: begin
					hi  = ($urandom_range(39) == 0) ? 8'd1 : 8'd0;
					lo  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(8));
					len = {hi, lo};
					send_item(1'b1, cur_long, 1'b0);
					send_item(1'($urandom), hi, 1'b0);
					send_item(1'($urandom), lo, 1'b0);
				end
			endcase
			for (k = 0; k < len; k++)
				send_item(1'($urandom), 8'($urandom), 1'b0);
		end else if (pick < 90) begin
			send_item(1'($urandom), 8'($urandom), 1'b0);
		end else begin
			form = $urandom_range(2);
			if (form == 0) begin
				n   = $urandom_range(1, 8);
				len = $urandom_range(n - 1);
				send_item(1'b0, LEAD_EXT + 8'(n), 1'b0);
			end else if (form == 1) begin
				len = $urandom_range(4);
				send_item(1'b1, 8'd5, 1'b0);
			end else begin
				len = 0;
			end
			for (k = 0; k < len; k++)
				send_item(1'($urandom), 8'($urandom), 1'b0);
			send_item(1'($urandom), 8'($urandom), 1'b1);
		end
	endtask

	initial begin
		int ph;
		int target;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_SHORT_CODE;
		cfg_data       = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		cur_short      = SHORT_CODE_RST;
		cur_long       = LONG_CODE_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed fields with the codes at their reset values.
		// Largest direct number, then the extended lead alone.
		send_item(1'b0, 8'h7F, 1'b0);
		send_item(1'b0, LEAD_EXT, 1'b0);
		// Eight-byte number that wraps; operation flips inside the field.
		send_item(1'b0, NUM_LEAD_MAX, 1'b0);
		send_item(1'b1, 8'hF2, 1'b0);
		send_item(1'b1, 8'h34, 1'b0);
		send_item(1'b1, 8'h56, 1'b0);
		send_item(1'b1, 8'h78, 1'b0);
		send_item(1'b1, 8'h9A, 1'b0);
		send_item(1'b1, 8'hBC, 1'b0);
		send_item(1'b1, 8'hDE, 1'b0);
		send_item(1'b1, 8'hF0, 1'b0);
		// Number lead just above the limit.
		send_item(1'b0, NUM_LEAD_MAX + 8'd1, 1'b0);
		// Empty string, then a two-byte string read with the number kind.
		send_item(1'b1, 8'h00, 1'b0);
		send_item(1'b1, 8'h02, 1'b0);
		send_item(1'b0, 8'h41, 1'b0);
		send_item(1'b0, 8'h42, 1'b0);
		// One-byte length after the short code.
		send_item(1'b1, SHORT_CODE_RST, 1'b0);
		send_item(1'b0, 8'h01, 1'b0);
		send_item(1'b0, 8'hFF, 1'b0);
		// String lead that matches neither code.
		send_item(1'b1, LEAD_EXT, 1'b0);
		// End of input while idle.
		send_item(1'b1, 8'h00, 1'b1);
		// Largest long length, cut short by end of input.
		send_item(1'b1, LONG_CODE_RST, 1'b0);
		send_item(1'b0, 8'hFF, 1'b0);
		send_item(1'b0, 8'hFF, 1'b0);
		send_item(1'b0, 8'h55, 1'b0);
		send_item(1'b0, 8'hAA, 1'b1);

		// Random phases, each with its own codes and flow-control pressure.
		for (ph = 0; ph < 4; ph++) begin
			settle();
			set_codes(short_set[ph], long_set[ph]);
			src_idle_pct   = src_pct[ph];
			sink_stall_pct = sink_pct[ph];
			target         = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				send_field();
		end
		settle();

		@(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
